// File: src/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int unsigned HISTORY_BITS_DEF = 15;
	localparam int unsigned ADDR_W           = 32;
	localparam int unsigned CTR_W            = 2;

	localparam logic [CTR_W-1:0] CTR_MAX = 2'b11;
	localparam logic [CTR_W-1:0] CTR_MIN = 2'b00;

	typedef struct packed {
		logic [ADDR_W-1:0] branch_address;
		logic              taken;
	} in_item_t;

	typedef struct packed {
		logic predicted_taken;
		logic prediction_correct;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic accept;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} status_t;

endpackage

// File: src/gbp_ctrl.sv
// ----------------------------------------------------------------------------
// gbp_ctrl
// Sequencer for table clearing, lookup and counter write-back.
// ----------------------------------------------------------------------------
module gbp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gbp_pkg::status_t status,
	output gbp_pkg::cmd_t    cmd
);

	gbp_pkg::state_t state_q;
	gbp_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbp_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			gbp_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = gbp_pkg::ST_IDLE;
				end
			end
			gbp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = gbp_pkg::ST_UPDATE;
				end
			end
			gbp_pkg::ST_UPDATE: begin
				// result slot free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.update = 1'b1;
					state_d    = gbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbp_pkg::ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/gbp_datapath.sv
// ----------------------------------------------------------------------------
// gbp_datapath
// Global history, counter table, index hash and result register.
// ----------------------------------------------------------------------------
module gbp_datapath #(
	parameter int unsigned HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  gbp_pkg::in_item_t  in_data,
	output gbp_pkg::out_item_t out_data,
	input  gbp_pkg::cmd_t      cmd,
	output gbp_pkg::status_t   status
);

	localparam int unsigned DEPTH = 1 << HISTORY_BITS;

	logic [gbp_pkg::CTR_W-1:0] table_mem [DEPTH];

	logic                      hash_q;
	logic [HISTORY_BITS-1:0]   hist_q;
	logic [HISTORY_BITS-1:0]   clr_q;
	logic [HISTORY_BITS-1:0]   idx_q;
	logic                      taken_q;
	logic [gbp_pkg::CTR_W-1:0] ctr_q;
	gbp_pkg::out_item_t        out_q;

	logic [HISTORY_BITS-1:0]   idx_in;
	logic [gbp_pkg::CTR_W-1:0] ctr_next;

	assign idx_in = hash_q ? (in_data.branch_address[HISTORY_BITS-1:0] ^ hist_q) : hist_q;

	// saturating up/down counter
	always_comb begin
		ctr_next = ctr_q;
		if (taken_q) begin
			if (ctr_q != gbp_pkg::CTR_MAX) begin
				ctr_next = ctr_q + gbp_pkg::CTR_W'(1);
			end
		end else begin
			if (ctr_q != gbp_pkg::CTR_MIN) begin
				ctr_next = ctr_q - gbp_pkg::CTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 1'b1;
			hist_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_we) begin
				hash_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + HISTORY_BITS'(1);
			end
			if (cmd.update) begin
				hist_q <= (hist_q << 1) | HISTORY_BITS'(taken_q);
			end
		end
	end

	// table write port and registered read
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			table_mem[clr_q] <= gbp_pkg::CTR_MIN;
		end else if (cmd.update) begin
			table_mem[idx_q] <= ctr_next;
		end
		if (cmd.accept) begin
			ctr_q <= table_mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q   <= idx_in;
			taken_q <= in_data.taken;
		end
		if (cmd.update) begin
			out_q.predicted_taken    <= ctr_q[gbp_pkg::CTR_W-1];
			out_q.prediction_correct <= (ctr_q[gbp_pkg::CTR_W-1] == taken_q);
		end
	end

	assign out_data        = out_q;
	assign status.clr_last = (clr_q == '1);

endmodule

// File: src/gshare_branch_predictor.sv
// After reset the counter table is swept to zero, one entry per cycle, so in_ready stays
// low until all 2^HISTORY_BITS entries (32768 at the default width) are cleared; configuration writes are
// taken during that time. Afterwards each branch is handled in two steps: one reads its
// counter from the single-ported table and one writes the updated counter back and
// shifts the history; no new branch is taken until the write-back is done. A result sits
// in an output register, and the next branch is taken while it waits there.
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare predictor with 2-bit saturating counters and a global history.
// ----------------------------------------------------------------------------
module gshare_branch_predictor #(
	parameter int unsigned HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gbp_pkg::out_item_t out_data
);

	gbp_pkg::cmd_t    cmd;
	gbp_pkg::status_t status;

	gbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gbp_datapath #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// File: tb/tb_gshare_branch_predictor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gshare_branch_predictor
// Drives resolved branches into the gshare predictor and checks every
// prediction against a local copy of the history and counter table. Both
// hashed and history-only indexing are exercised, counters are pushed to
// both saturation limits, and random stalls and gaps on both sides,
// including long output hold-offs, keep the handshake under pressure.
// ----------------------------------------------------------------------------
module tb_gshare_branch_predictor;

	localparam int HB           = gbp_pkg::HISTORY_BITS_DEF;
	localparam int TABLE_SIZE   = 1 << HB;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASE_ITEMS  = 240;
	localparam int NUM_PHASES   = 6;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	gbp_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	gbp_pkg::out_item_t out_data;

	// predictor state
	bit [1:0]    pht [TABLE_SIZE];
	bit [HB-1:0] ghr       = '0;
	bit          hash_mode = 1'b1;

	gbp_pkg::in_item_t  pending_branches[$];
	gbp_pkg::out_item_t expected_outcomes[$];
	gbp_pkg::out_item_t want_outcome;

	bit [HB-1:0] gen_hist = '0;
	int queued_cnt   = 0;
	int accepted_cnt = 0;
	int results_seen = 0;
	int errors       = 0;
	int cycle_cnt    = 0;

	int send_gap    = 0;
	int send_calm   = 0;
	int recv_stall  = 0;
	int recv_calm   = 0;
	int hold_left   = 0;

	bit [HB-1:0] hot_index [16];
	int          hot_bias  [16];

	gshare_branch_predictor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	function automatic gbp_pkg::out_item_t predict_branch(gbp_pkg::in_item_t br);
		bit [HB-1:0]        idx;
		bit [1:0]           ctr;
		gbp_pkg::out_item_t res;
		idx = hash_mode ? (br.branch_address[HB-1:0] ^ ghr) : ghr;
		ctr = pht[idx];
		res.predicted_taken    = ctr[1];
		res.prediction_correct = (ctr[1] == br.taken);
		if (br.taken) begin
			if (ctr != gbp_pkg::CTR_MAX)
				ctr = ctr + 2'd1;
		end else if (ctr != gbp_pkg::CTR_MIN) begin
			ctr = ctr - 2'd1;
		end
		pht[idx] = ctr;
		ghr = {ghr[HB-2:0], br.taken};
		return res;
	endfunction

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// address that lands on a chosen entry in hashed mode
	function automatic logic [31:0] aim_at(bit [HB-1:0] target, logic [31-HB:0] upper);
		return {upper, target ^ gen_hist};
	endfunction

	task automatic push_branch(logic [31:0] addr, logic taken);
		gbp_pkg::in_item_t br;
		br.branch_address = addr;
		br.taken          = taken;
		pending_branches.push_back(br);
		gen_hist = {gen_hist[HB-2:0], taken};
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_hash_mode(bit v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		hash_mode = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_outcomes.push_back(predict_branch(in_data));
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_branches.size() > 0) begin
					in_data  <= pending_branches.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					errors++;
					$display("%0t: result with no branch pending: expected none, actual %p",
						$time, out_data);
				end else begin
					want_outcome = expected_outcomes.pop_front();
					if (out_data.predicted_taken !== want_outcome.predicted_taken) begin
						errors++;
						$display("%0t: predicted_taken expected %0b actual %0b", $time,
							want_outcome.predicted_taken, out_data.predicted_taken);
					end
					if (out_data.prediction_correct !== want_outcome.prediction_correct) begin
						errors++;
						$display("%0t: prediction_correct expected %0b actual %0b", $time,
							want_outcome.prediction_correct, out_data.prediction_correct);
					end
				end
				results_seen++;
				// long hold-off so the block backs up into its input
				if (results_seen == 300 || results_seen == 1000)
					hold_left = 400;
				else
					recv_stall = pick_gap(recv_calm);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit [31:0] pat;
		int        period;
		int        pat_pos;
		int        r;
		int        k;
		logic      tk;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// written during the clearing sweep
		write_hash_mode(1'b1);

		// hashed mode: floor, wide addresses, climb to the top and back down
		push_branch(32'h0000_0000, 1'b0);
		push_branch(32'hFFFF_FFFF, 1'b0);
		repeat (4) push_branch(aim_at(15'h1234, '0), 1'b1);
		push_branch(aim_at(15'h1234, '1), 1'b1);
		repeat (4) push_branch(aim_at(15'h1234, 17'h0A5A5), 1'b0);
		push_branch(32'hFFFF_FFFF, 1'b1);
		push_branch(32'h8000_0000, 1'b1);

		// history only: all taken saturates the all-ones entry
		write_hash_mode(1'b0);
		repeat (20) push_branch($urandom, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_hash_mode((p % 2) == 0);
			for (int h = 0; h < 16; h++) begin
				hot_index[h] = HB'($urandom);
				case ($urandom_range(0, 3))
					0: hot_bias[h] = 95;
					1: hot_bias[h] = 5;
					2: hot_bias[h] = 70;
					default: hot_bias[h] = 30;
				endcase
			end
			pat     = $urandom;
			period  = $urandom_range(2, 12);
			pat_pos = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 60 == 0) begin
					pat    = $urandom;
					period = $urandom_range(2, 12);
				end
				r = $urandom_range(0, 99);
				if (hash_mode) begin
					if (r < 70) begin
						k  = $urandom_range(0, 15);
						tk = ($urandom_range(0, 99) < hot_bias[k]);
						push_branch(aim_at(hot_index[k], (32-HB)'($urandom)), tk);
					end else begin
						push_branch($urandom, 1'($urandom_range(0, 1)));
					end
				end else begin
					if (r < 75) begin
						tk = pat[pat_pos % period];
						pat_pos++;
					end else begin
						tk = 1'($urandom_range(0, 1));
					end
					push_branch($urandom, tk);
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
